### src/spfs_pkg.sv
// ----------------------------------------------------------------------------
// spfs_pkg: shared types and constants for the sensor failover selector
// Channel order, register indexes, message kinds and the kind-to-channel map.
// ----------------------------------------------------------------------------
package spfs_pkg;

	// default sizing
	localparam int NUM_SENSORS_DEF  = 8;
	localparam int ELAPSED_BITS_DEF = 16;

	// field widths
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 3;
	localparam int SENS_W   = 4;
	localparam int RANK_W   = 4;
	localparam int CNT_W    = 4;
	localparam int RANKS_W  = 32;
	localparam int STEP_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// logical channels, also mask bit positions
	localparam int CH_POSITION = 0;
	localparam int CH_ATTITUDE = 1;
	localparam int CH_SPEED    = 2;
	localparam int CH_LINEAR   = 3;
	localparam int CH_ANGULAR  = 4;
	localparam int CH_COUNT    = 5;

	localparam logic [RANK_W-1:0] RANK_UNLISTED = 4'hF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_POSITION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_ATTITUDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_SPEED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_LINEAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_ANGULAR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ELAPSED_STEP  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd7;

	// register reset values
	localparam logic [CNT_W-1:0]   SENSOR_COUNT_RST  = 4'd0;
	localparam logic [RANKS_W-1:0] RANKS_RST         = 32'hFFFF_FFFF;
	localparam logic [STEP_W-1:0]  ELAPSED_STEP_RST  = 16'd1;
	localparam logic [STEP_W-1:0]  TIMEOUT_LIMIT_RST = 16'd100;

	// message kinds
	localparam logic [KIND_W-1:0] KIND_AHRS     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POSITION = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VELOCITY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DOPPLER  = 2'd3;

	typedef logic [CH_COUNT-1:0] ch_mask_t;

	// configuration register set
	typedef struct packed {
		logic [CNT_W-1:0]                  sensor_count;
		logic [CH_COUNT-1:0][RANKS_W-1:0]  ranks;
		logic [STEP_W-1:0]                 elapsed_step;
		logic [STEP_W-1:0]                 timeout_limit;
	} cfg_t;

	// per-channel outcome of one request
	typedef struct packed {
		logic              taken;
		logic              freed;
		logic [SENS_W-1:0] active;
	} chan_res_t;

	// channels fed by each message kind
	function automatic ch_mask_t kind_feeds(input logic [KIND_W-1:0] k);
		ch_mask_t m;
		m = '0;
		case (k)
			KIND_AHRS: begin
				m[CH_ATTITUDE] = 1'b1;
				m[CH_ANGULAR]  = 1'b1;
				m[CH_LINEAR]   = 1'b1;
			end
			KIND_POSITION: m[CH_POSITION] = 1'b1;
			KIND_VELOCITY: m[CH_SPEED]    = 1'b1;
			KIND_DOPPLER:  m[CH_LINEAR]   = 1'b1;
			default:       m = '0;
		endcase
		return m;
	endfunction

endpackage

### src/spfs_cfg.sv
// ----------------------------------------------------------------------------
// spfs_cfg: configuration register file
// Write-only registers: sensor count, five rank tables, step and timeout.
// ----------------------------------------------------------------------------
module spfs_cfg
	import spfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_count  <= SENSOR_COUNT_RST;
			cfg_q.ranks         <= {CH_COUNT{RANKS_RST}};
			cfg_q.elapsed_step  <= ELAPSED_STEP_RST;
			cfg_q.timeout_limit <= TIMEOUT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSOR_COUNT:  cfg_q.sensor_count         <= cfg_data[CNT_W-1:0];
				REG_RANK_POSITION: cfg_q.ranks[CH_POSITION]   <= cfg_data[RANKS_W-1:0];
				REG_RANK_ATTITUDE: cfg_q.ranks[CH_ATTITUDE]   <= cfg_data[RANKS_W-1:0];
				REG_RANK_SPEED:    cfg_q.ranks[CH_SPEED]      <= cfg_data[RANKS_W-1:0];
				REG_RANK_LINEAR:   cfg_q.ranks[CH_LINEAR]     <= cfg_data[RANKS_W-1:0];
				REG_RANK_ANGULAR:  cfg_q.ranks[CH_ANGULAR]    <= cfg_data[RANKS_W-1:0];
				REG_ELAPSED_STEP:  cfg_q.elapsed_step         <= cfg_data[STEP_W-1:0];
				REG_TIMEOUT_LIMIT: cfg_q.timeout_limit        <= cfg_data[STEP_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/spfs_channel.sv
// ----------------------------------------------------------------------------
// spfs_channel: one logical channel's arbitration state
// Holds active sensor, its rank and elapsed ticks; claims and times out.
// ----------------------------------------------------------------------------
module spfs_channel
	import spfs_pkg::*;
#(
	parameter int NUM_SENSORS  = NUM_SENSORS_DEF,
	parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed,
	input  logic              update,
	input  logic [IDX_W-1:0]  idx,
	input  logic [RANK_W-1:0] rank,
	input  logic [STEP_W-1:0] step,
	input  logic [STEP_W-1:0] limit,
	output chan_res_t         res
);

	localparam int SUM_W = ((ELAPSED_BITS > STEP_W) ? ELAPSED_BITS : STEP_W) + 1;
	localparam logic [SENS_W-1:0] SENSOR_NONE = SENS_W'(NUM_SENSORS);
	localparam logic [SUM_W-1:0]  ELAPSED_MAX = SUM_W'({ELAPSED_BITS{1'b1}});

	logic [SENS_W-1:0]       sensor_q;
	logic [RANK_W-1:0]       rank_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;

	logic                    claim;
	logic                    expired;
	logic [SENS_W-1:0]       sensor_c;
	logic [RANK_W-1:0]       rank_c;
	logic [ELAPSED_BITS-1:0] base;
	logic [SUM_W-1:0]        sum;
	logic [ELAPSED_BITS-1:0] elapsed_n;
	logic [SENS_W-1:0]       sensor_n;
	logic [RANK_W-1:0]       rank_n;

	// claim by a listed sensor of equal or better rank
	always_comb begin
		claim    = (rank != RANK_UNLISTED) && (rank <= rank_q);
		sensor_c = claim ? {1'b0, idx} : sensor_q;
		rank_c   = claim ? rank : rank_q;
		base     = claim ? '0 : elapsed_q;
	end

	// saturating elapsed update and timeout check
	always_comb begin
		sum       = SUM_W'(base) + SUM_W'(step);
		elapsed_n = (sum > ELAPSED_MAX) ? ELAPSED_MAX[ELAPSED_BITS-1:0]
		                                : sum[ELAPSED_BITS-1:0];
		expired   = SUM_W'(elapsed_n) >= SUM_W'(limit);
		sensor_n  = expired ? SENSOR_NONE : sensor_c;
		rank_n    = expired ? RANK_UNLISTED : rank_c;
	end

	// result seen by the output stage
	always_comb begin
		res.taken  = feed && claim;
		res.freed  = feed && expired && (sensor_c != SENSOR_NONE);
		res.active = feed ? sensor_n : sensor_q;
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q  <= SENSOR_NONE;
			rank_q    <= RANK_UNLISTED;
			elapsed_q <= '0;
		end else if (update && feed) begin
			sensor_q  <= sensor_n;
			rank_q    <= rank_n;
			elapsed_q <= elapsed_n;
		end
	end

endmodule

### src/sensor_priority_failover_selector.sv
// ----------------------------------------------------------------------------
// sensor_priority_failover_selector: priority sensor failover with timeout
// Routes each sensor message tag to its channels, picks the best-ranked sensor
// per channel and drops it once elapsed ticks reach the timeout.
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------------
//   input     in_valid / in_ready   kind, sensor_index
//   output    out_valid / out_ready accepted, taken_mask, timeout_mask,
//                                   active_position .. active_angular_rate
//   config    cfg_we                cfg_index, cfg_data
//
// One request per cycle sustained while out_ready is high; each accept passes
// input register, then result register, to out_valid. The channel update is
// a rank compare, a saturating add and a timeout compare between the two.
// Reset clears pipeline valids, channel state and loads register defaults.
// A stalled output holds both stages; in_ready follows out_ready through them.
//
module sensor_priority_failover_selector
	import spfs_pkg::*;
#(
	parameter int NUM_SENSORS  = NUM_SENSORS_DEF,
	parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [IDX_W-1:0]     sensor_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic [CH_COUNT-1:0]  taken_mask,
	output logic [CH_COUNT-1:0]  timeout_mask,
	output logic [SENS_W-1:0]    active_position,
	output logic [SENS_W-1:0]    active_attitude,
	output logic [SENS_W-1:0]    active_speed,
	output logic [SENS_W-1:0]    active_linear_rate,
	output logic [SENS_W-1:0]    active_angular_rate,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t cfg;

	logic              vld_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              vld_s2;
	logic              accepted_s2;
	ch_mask_t          taken_s2;
	ch_mask_t          freed_s2;
	logic [CH_COUNT-1:0][SENS_W-1:0] active_s2;

	logic      adv_s2;
	logic      adv_s1;
	logic      acc;
	ch_mask_t  feeds;
	chan_res_t res [CH_COUNT];

	// configuration registers
	spfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline flow control
	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = vld_s1 && adv_s2;
	assign in_ready = !vld_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			idx_s1  <= sensor_index;
		end
	end

	// sensor admission and channel routing
	always_comb begin
		acc   = ({1'b0, idx_s1} < cfg.sensor_count) &&
		        ({1'b0, idx_s1} < CNT_W'(NUM_SENSORS));
		feeds = acc ? kind_feeds(kind_s1) : '0;
	end

	// per-channel arbitration
	for (genvar c = 0; c < CH_COUNT; c++) begin : g_ch
		spfs_channel #(
			.NUM_SENSORS  (NUM_SENSORS),
			.ELAPSED_BITS (ELAPSED_BITS)
		) u_channel (
			.clk    (clk),
			.arst_n (arst_n),
			.feed   (feeds[c]),
			.update (adv_s1),
			.idx    (idx_s1),
			.rank   (cfg.ranks[c][RANK_W*idx_s1 +: RANK_W]),
			.step   (cfg.elapsed_step),
			.limit  (cfg.timeout_limit),
			.res    (res[c])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			accepted_s2 <= acc;
			for (int c = 0; c < CH_COUNT; c++) begin
				taken_s2[c]  <= res[c].taken;
				freed_s2[c]  <= res[c].freed;
				active_s2[c] <= res[c].active;
			end
		end
	end

	// output ports
	assign out_valid           = vld_s2;
	assign accepted            = accepted_s2;
	assign taken_mask          = taken_s2;
	assign timeout_mask        = freed_s2;
	assign active_position     = active_s2[CH_POSITION];
	assign active_attitude     = active_s2[CH_ATTITUDE];
	assign active_speed        = active_s2[CH_SPEED];
	assign active_linear_rate  = active_s2[CH_LINEAR];
	assign active_angular_rate = active_s2[CH_ANGULAR];

endmodule

### sim/sensor_priority_failover_selector_test.sv
// ----------------------------------------------------------------------------
// sensor_priority_failover_selector_test: self-checking bench for the selector
// Sends sensor message tags through the valid/ready input, predicts each
// selection from a local model of the per-channel rank, elapsed and timeout
// state, and checks every output field in order. Directed cases come first,
// then randomized configuration phases and a long output stall.
// ----------------------------------------------------------------------------
module sensor_priority_failover_selector_test;
	import spfs_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int PHASE_REQUESTS = 200;
	localparam logic [SENS_W-1:0] SENSOR_NONE = SENS_W'(NUM_SENSORS_DEF);

	// predicted outcome of one request
	typedef struct packed {
		logic                             accepted;
		ch_mask_t                         taken;
		ch_mask_t                         freed;
		logic [CH_COUNT-1:0][SENS_W-1:0]  active;
	} selection_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind         = '0;
	logic [IDX_W-1:0]     sensor_index = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic                 accepted;
	logic [CH_COUNT-1:0]  taken_mask;
	logic [CH_COUNT-1:0]  timeout_mask;
	logic [SENS_W-1:0]    active_position;
	logic [SENS_W-1:0]    active_attitude;
	logic [SENS_W-1:0]    active_speed;
	logic [SENS_W-1:0]    active_linear_rate;
	logic [SENS_W-1:0]    active_angular_rate;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;

	// local copy of registers and channel state
	cfg_t                         regs_now;
	logic [SENS_W-1:0]            chan_sensor  [CH_COUNT];
	logic [RANK_W-1:0]            chan_rank    [CH_COUNT];
	logic [ELAPSED_BITS_DEF-1:0]  chan_elapsed [CH_COUNT];

	selection_t pending_selections[$];

	int n_errors       = 0;
	int n_requests     = 0;
	int n_ignored      = 0;
	int n_checked      = 0;
	int n_claims       = 0;
	int n_drops        = 0;
	int n_phases       = 0;
	int n_input_stalls = 0;
	int burst_left     = 0;
	int hold_req       = 0;
	int cycles         = 0;
	bit gapless        = 1'b0;

	sensor_priority_failover_selector u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.kind                (kind),
		.sensor_index        (sensor_index),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.accepted            (accepted),
		.taken_mask          (taken_mask),
		.timeout_mask        (timeout_mask),
		.active_position     (active_position),
		.active_attitude     (active_attitude),
		.active_speed        (active_speed),
		.active_linear_rate  (active_linear_rate),
		.active_angular_rate (active_angular_rate),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t  timeout with %0d selections outstanding", $time,
					pending_selections.size());
				$display("** sensor_priority_failover_selector: FAILED **");
				$finish;
			end
		end
	end

	// model state after reset
	task automatic reset_model();
		regs_now.sensor_count  = SENSOR_COUNT_RST;
		regs_now.elapsed_step  = ELAPSED_STEP_RST;
		regs_now.timeout_limit = TIMEOUT_LIMIT_RST;
		for (int c = 0; c < CH_COUNT; c++) begin
			regs_now.ranks[c] = RANKS_RST;
			chan_sensor[c]    = SENSOR_NONE;
			chan_rank[c]      = RANK_UNLISTED;
			chan_elapsed[c]   = '0;
		end
	endtask

	// channels that a message kind feeds
	function automatic ch_mask_t channels_of(input logic [KIND_W-1:0] k);
		ch_mask_t one;
		one = ch_mask_t'(1);
		case (k)
			KIND_AHRS:     return (one << CH_ATTITUDE) | (one << CH_LINEAR) | (one << CH_ANGULAR);
			KIND_POSITION: return one << CH_POSITION;
			KIND_VELOCITY: return one << CH_SPEED;
			default:       return one << CH_LINEAR;
		endcase
	endfunction

	// rank claim, saturating elapsed add and timeout drop per fed channel
	function automatic selection_t predict_selection(input logic [KIND_W-1:0] k,
			input logic [IDX_W-1:0] idx);
		selection_t sel;
		ch_mask_t feeds;
		logic [RANK_W-1:0] rank;
		logic [ELAPSED_BITS_DEF:0] sum;
		sel = '0;
		if (CNT_W'(idx) < regs_now.sensor_count) begin
			sel.accepted = 1'b1;
			feeds = channels_of(k);
			for (int c = 0; c < CH_COUNT; c++) begin
				if (feeds[c]) begin
					rank = regs_now.ranks[c][RANK_W*idx +: RANK_W];
					if (rank != RANK_UNLISTED && rank <= chan_rank[c]) begin
						chan_sensor[c]  = SENS_W'(idx);
						chan_rank[c]    = rank;
						chan_elapsed[c] = '0;
						sel.taken[c]    = 1'b1;
					end
					sum = chan_elapsed[c] + regs_now.elapsed_step;
					chan_elapsed[c] = sum[ELAPSED_BITS_DEF] ? '1 : sum[ELAPSED_BITS_DEF-1:0];
					if (chan_elapsed[c] >= regs_now.timeout_limit) begin
						sel.freed[c]   = (chan_sensor[c] != SENSOR_NONE);
						chan_sensor[c] = SENSOR_NONE;
						chan_rank[c]   = RANK_UNLISTED;
					end
				end
			end
		end
		for (int c = 0; c < CH_COUNT; c++)
			sel.active[c] = chan_sensor[c];
		n_claims += $countones(sel.taken);
		n_drops  += $countones(sel.freed);
		if (!sel.accepted)
			n_ignored++;
		return sel;
	endfunction

	// register write, mirrored into the local copy
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SENSOR_COUNT:  regs_now.sensor_count = data[CNT_W-1:0];
			REG_RANK_POSITION, REG_RANK_ATTITUDE, REG_RANK_SPEED,
			REG_RANK_LINEAR, REG_RANK_ANGULAR:
				regs_now.ranks[idx - REG_RANK_POSITION] = data[RANKS_W-1:0];
			REG_ELAPSED_STEP:  regs_now.elapsed_step = data[STEP_W-1:0];
			default:           regs_now.timeout_limit = data[STEP_W-1:0];
		endcase
	endtask

	// full register set, only while the block is idle
	task automatic program_regs(input cfg_t c);
		write_reg(REG_SENSOR_COUNT, CFG_DAT_W'(c.sensor_count));
		for (int ch = 0; ch < CH_COUNT; ch++)
			write_reg(CFG_IDX_W'(REG_RANK_POSITION + ch), c.ranks[ch]);
		write_reg(REG_ELAPSED_STEP, CFG_DAT_W'(c.elapsed_step));
		write_reg(REG_TIMEOUT_LIMIT, CFG_DAT_W'(c.timeout_limit));
		cfg_we <= 1'b0;
		n_phases++;
	endtask

	// one request, with bursty gaps unless the sender runs flat out
	task automatic send_tag(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx);
		int gap;
		selection_t sel;
		if (!gapless) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 12);
			end
			burst_left--;
		end
		in_valid     <= 1'b1;
		kind         <= k;
		sensor_index <= idx;
		@(posedge clk);
		while (!in_ready) begin
			n_input_stalls++;
			@(posedge clk);
		end
		sel = predict_selection(k, idx);
		pending_selections.insert(pending_selections.size(), sel);
		n_requests++;
	endtask

	// drain everything outstanding, then let the pipeline go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_selections.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// output stall pattern, with an occasional long hold-off
	initial begin : receiver
		int stretch;
		int hold;
		logic rdy;
		stretch = 0;
		hold    = 0;
		rdy     = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold     = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					case ($urandom_range(0, 5))
						0: begin
							rdy     = 1'b0;
							stretch = $urandom_range(1, 4);
						end
						1: begin
							rdy     = 1'b1;
							stretch = $urandom_range(40, 80);
						end
						default: begin
							rdy     = 1'($urandom_range(0, 1));
							stretch = $urandom_range(1, 6);
						end
					endcase
				end
				stretch--;
				out_ready <= rdy;
			end
		end
	end

	// field compare
	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t  %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		selection_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_selections.size() == 0) begin
				n_errors++;
				$display("%0t  result with no request outstanding", $time);
			end else begin
				want = pending_selections.pop_front();
				n_checked++;
				check_field("accepted", 16'(want.accepted), 16'(accepted));
				check_field("taken_mask", 16'(want.taken), 16'(taken_mask));
				check_field("timeout_mask", 16'(want.freed), 16'(timeout_mask));
				check_field("active_position", 16'(want.active[CH_POSITION]),
					16'(active_position));
				check_field("active_attitude", 16'(want.active[CH_ATTITUDE]),
					16'(active_attitude));
				check_field("active_speed", 16'(want.active[CH_SPEED]), 16'(active_speed));
				check_field("active_linear_rate", 16'(want.active[CH_LINEAR]),
					16'(active_linear_rate));
				check_field("active_angular_rate", 16'(want.active[CH_ANGULAR]),
					16'(active_angular_rate));
			end
		end
	end

	// register set used by the directed cases
	function automatic cfg_t directed_regs();
		cfg_t c;
		c.sensor_count       = 4'd8;
		c.ranks[CH_POSITION] = 32'h0FFF_FF12;
		c.ranks[CH_ATTITUDE] = 32'h0FF5_5FFF;
		c.ranks[CH_SPEED]    = 32'hFFFF_FEFF;
		c.ranks[CH_LINEAR]   = 32'h0FF5_5FFF;
		c.ranks[CH_ANGULAR]  = 32'h0FF5_5FFF;
		c.elapsed_step       = 16'd1;
		c.timeout_limit      = 16'd4;
		return c;
	endfunction

	// random register set, weighted toward short timeouts and close ranks
	function automatic cfg_t random_regs();
		cfg_t c;
		int pick;
		case ($urandom_range(0, 3))
			0:       c.sensor_count = 4'd8;
			1:       c.sensor_count = CNT_W'($urandom_range(9, 15));
			default: c.sensor_count = CNT_W'($urandom_range(1, 8));
		endcase
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			for (int s = 0; s < NUM_SENSORS_DEF; s++) begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					c.ranks[ch][RANK_W*s +: RANK_W] = RANK_UNLISTED;
				else if (pick < 5)
					c.ranks[ch][RANK_W*s +: RANK_W] = RANK_W'($urandom_range(0, 14));
				else
					c.ranks[ch][RANK_W*s +: RANK_W] = RANK_W'($urandom_range(0, 2));
			end
		end
		case ($urandom_range(0, 7))
			0:       c.elapsed_step = '0;
			1:       c.elapsed_step = '1;
			2:       c.elapsed_step = STEP_W'($urandom);
			default: c.elapsed_step = STEP_W'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 7))
			0:       c.timeout_limit = '0;
			1:       c.timeout_limit = '1;
			2:       c.timeout_limit = STEP_W'($urandom);
			default: c.timeout_limit = STEP_W'($urandom_range(2, 40));
		endcase
		return c;
	endfunction

	// reset registers: no sensor configured, every message ignored
	task automatic test_reset_defaults();
		send_tag(KIND_AHRS, 3'd0);
		send_tag(KIND_DOPPLER, 3'd7);
		settle_block();
	endtask

	// claims, equal-rank takeover, weaker and unlisted sensors, timeout drop
	task automatic test_claim_and_failover();
		program_regs(directed_regs());
		send_tag(KIND_POSITION, 3'd0);
		send_tag(KIND_POSITION, 3'd2);
		send_tag(KIND_POSITION, 3'd1);
		send_tag(KIND_POSITION, 3'd0);
		send_tag(KIND_POSITION, 3'd0);
		send_tag(KIND_POSITION, 3'd0);
		send_tag(KIND_POSITION, 3'd0);
		send_tag(KIND_AHRS, 3'd3);
		send_tag(KIND_AHRS, 3'd4);
		send_tag(KIND_DOPPLER, 3'd4);
		send_tag(KIND_VELOCITY, 3'd2);
		send_tag(KIND_VELOCITY, 3'd5);
		send_tag(KIND_AHRS, 3'd7);
		send_tag(KIND_DOPPLER, 3'd7);
		settle_block();
	endtask

	// zero limit, step at the limit, saturation, count above and below range
	task automatic test_timeout_edges();
		cfg_t c;
		c = directed_regs();
		c.elapsed_step  = '0;
		c.timeout_limit = '0;
		program_regs(c);
		send_tag(KIND_POSITION, 3'd7);
		send_tag(KIND_VELOCITY, 3'd5);
		send_tag(KIND_VELOCITY, 3'd5);
		settle_block();
		c.elapsed_step  = '1;
		c.timeout_limit = '1;
		program_regs(c);
		send_tag(KIND_POSITION, 3'd0);
		settle_block();
		c.elapsed_step = 16'd40000;
		program_regs(c);
		send_tag(KIND_POSITION, 3'd1);
		send_tag(KIND_POSITION, 3'd2);
		settle_block();
		c.sensor_count = 4'd15;
		program_regs(c);
		send_tag(KIND_AHRS, 3'd7);
		send_tag(KIND_DOPPLER, 3'd7);
		settle_block();
		c.sensor_count = 4'd3;
		program_regs(c);
		send_tag(KIND_POSITION, 3'd3);
		send_tag(KIND_AHRS, 3'd7);
		send_tag(KIND_POSITION, 3'd2);
		settle_block();
	endtask

	// random phases, each with its own register set
	task automatic test_random_phases();
		cfg_t c;
		int live;
		int taken_here;
		logic [IDX_W-1:0] idx;
		for (int p = 0; p < 8; p++) begin
			c = random_regs();
			if (p == 0) begin
				c.sensor_count = 4'd8;
				c.ranks        = '0;
			end else if (p == 1) begin
				c.sensor_count  = 4'd15;
				c.elapsed_step  = '1;
				c.timeout_limit = '1;
			end
			program_regs(c);
			live = (c.sensor_count > NUM_SENSORS_DEF) ? NUM_SENSORS_DEF : c.sensor_count;
			taken_here = 0;
			while (taken_here < PHASE_REQUESTS) begin
				if ($urandom_range(0, 9) < 8)
					idx = IDX_W'($urandom_range(0, live - 1));
				else
					idx = IDX_W'($urandom_range(0, NUM_SENSORS_DEF - 1));
				if (idx < live)
					taken_here++;
				send_tag(KIND_W'($urandom_range(0, 3)), idx);
			end
			settle_block();
		end
	endtask

	// long output hold-off while the sender keeps pushing
	task automatic test_input_backpressure();
		cfg_t c;
		c = random_regs();
		c.sensor_count = 4'd8;
		program_regs(c);
		gapless  = 1'b1;
		hold_req = 200;
		for (int i = 0; i < 60; i++)
			send_tag(KIND_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)));
		gapless = 1'b0;
		settle_block();
	endtask

	// test sequence
	initial begin
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_claim_and_failover();
		test_timeout_edges();
		test_random_phases();
		test_input_backpressure();
		settle_block();
		$display("covered %0d requests (%0d ignored) over %0d register sets, %0d results checked",
			n_requests, n_ignored, n_phases, n_checked);
		$display("saw %0d channel claims, %0d timeout drops, %0d cycles of input stall",
			n_claims, n_drops, n_input_stalls);
		if (n_errors == 0)
			$display("** sensor_priority_failover_selector: PASSED **");
		else
			$display("** sensor_priority_failover_selector: FAILED **");
		$finish;
	end

endmodule
